>>> rtl/mhpq_pkg.sv
// Shared types and codes of the max-heap priority queue.
package mhpq_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } mhpq_req_t;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic signed [31:0] top_value;
    logic [4:0]         entry_count;
    logic [1:0]         status;
    logic               last;
  } mhpq_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_REM_LAST,
    ST_REM_RD,
    ST_REM_CMP,
    ST_LIST_RD,
    ST_LIST_OUT,
    ST_RESP
  } mhpq_state_t;

endpackage

>>> rtl/max_heap_priority_queue_core.sv
// Bounded binary max-heap priority queue held in one synchronous memory.
//
// A command is taken when start is high and busy is low; results appear for one cycle each
// with result_valid high and cannot be held off. Memory reads are registered, so each heap
// level costs a read state and a compare state: an insert climbs through ST_INS_RD and
// ST_INS_CMP, a remove first fetches the last entry in ST_REM_LAST and then descends through
// ST_REM_RD and ST_REM_CMP, and a list gives one entry per ST_LIST_RD and ST_LIST_OUT pair.
// Full, empty and unknown commands go straight to ST_RESP. The store needs no clearing after
// reset, since only written entries are ever read.
module max_heap_priority_queue_core #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mhpq_pkg::mhpq_req_t request,
  output logic              busy,
  output logic              result_valid,
  output mhpq_pkg::mhpq_rsp_t result
);
  import mhpq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [CAPACITY];

  mhpq_state_t        state, state_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      slot;
  logic signed [31:0] val;
  logic signed [31:0] item;
  logic signed [31:0] top;
  logic [1:0]         status_r;
  logic signed [31:0] rd0, rd1;

  logic               we;
  logic [AW-1:0]      waddr, raddr0, raddr1;
  logic signed [31:0] wdata;
  logic               emit_valid;
  mhpq_rsp_t          emit_rsp;

  logic [CW:0]   left, right;
  logic          has_left, has_right, pick_left, pick_right;
  logic          full;
  logic [CW-1:0] parent;

  assign left      = {slot, 1'b0};
  assign right     = {slot, 1'b1};
  assign has_left  = left <= {1'b0, count};
  assign has_right = right <= {1'b0, count};
  assign parent    = slot >> 1;
  assign full      = count >= CW'(CAPACITY);

  always_comb begin
    pick_left  = 1'b0;
    pick_right = 1'b0;
    if (has_right) begin
      if (rd0 >= rd1 && rd0 > val) begin
        pick_left = 1'b1;
      end else if (rd1 > rd0 && rd1 > val) begin
        pick_right = 1'b1;
      end
    end else if (has_left) begin
      pick_left = rd0 > val;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0 <= mem[raddr0];
    rd1 <= mem[raddr1];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (request.operation)
            OP_INSERT: state_next = full ? ST_RESP : ST_INS_RD;
            OP_REMOVE: state_next = (count == '0) ? ST_RESP : ST_REM_LAST;
            OP_LIST:   state_next = (count == '0) ? ST_RESP : ST_LIST_RD;
            default:   state_next = ST_RESP;
          endcase
        end
      end
      ST_INS_RD:   state_next = (slot <= CW'(1)) ? ST_RESP : ST_INS_CMP;
      ST_INS_CMP:  state_next = (rd0 < val) ? ST_INS_RD : ST_RESP;
      ST_REM_LAST: state_next = ST_REM_RD;
      ST_REM_RD:   state_next = has_left ? ST_REM_CMP : ST_RESP;
      ST_REM_CMP:  state_next = (pick_left || pick_right) ? ST_REM_RD : ST_RESP;
      ST_LIST_RD:  state_next = ST_LIST_OUT;
      ST_LIST_OUT: state_next = (slot == count) ? ST_IDLE : ST_LIST_RD;
      ST_RESP:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    we         = 1'b0;
    waddr      = AW'(slot - CW'(1));
    wdata      = val;
    raddr0     = AW'(slot - CW'(1));
    raddr1     = AW'(slot - CW'(1));
    emit_valid = 1'b0;
    emit_rsp.item_value  = item;
    emit_rsp.top_value   = (count != '0) ? top : 32'sd0;
    emit_rsp.entry_count = 5'(count);
    emit_rsp.status      = status_r;
    emit_rsp.last        = 1'b1;
    busy       = state != ST_IDLE;
    case (state)
      ST_IDLE: begin
        raddr0 = AW'(count - CW'(1));
      end
      ST_INS_RD: begin
        raddr0 = AW'(parent - CW'(1));
        we     = slot <= CW'(1);
      end
      ST_INS_CMP: begin
        we = 1'b1;
        if (rd0 < val) begin
          wdata = rd0;
        end
      end
      ST_REM_RD: begin
        raddr0 = AW'(left - (CW + 1)'(1));
        if (has_right) begin
          raddr1 = AW'(right - (CW + 1)'(1));
        end
        we = !has_left;
      end
      ST_REM_CMP: begin
        we = 1'b1;
        if (pick_left) begin
          wdata = rd0;
        end else if (pick_right) begin
          wdata = rd1;
        end
      end
      ST_LIST_OUT: begin
        emit_valid          = 1'b1;
        emit_rsp.item_value = rd0;
        emit_rsp.status     = STATUS_OK;
        emit_rsp.last       = slot == count;
      end
      ST_RESP: begin
        emit_valid = 1'b1;
      end
      default: begin
        emit_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit_valid;
      if (state == ST_IDLE && start) begin
        case (request.operation)
          OP_INSERT: begin
            if (!full) begin
              count <= count + CW'(1);
            end
          end
          OP_REMOVE: begin
            if (count != '0) begin
              count <= count - CW'(1);
            end
          end
          default: begin
            count <= count;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= emit_rsp;
    if (we && waddr == '0) begin
      top <= wdata;
    end
    case (state)
      ST_IDLE: begin
        val <= request.value;
        if (start) begin
          case (request.operation)
            OP_INSERT: begin
              item     <= 32'sd0;
              status_r <= full ? STATUS_FULL : STATUS_OK;
              slot     <= count + CW'(1);
            end
            OP_REMOVE: begin
              item     <= (count == '0) ? 32'sd0 : top;
              status_r <= (count == '0) ? STATUS_EMPTY : STATUS_OK;
              slot     <= CW'(1);
            end
            OP_LIST: begin
              item     <= 32'sd0;
              status_r <= (count == '0) ? STATUS_EMPTY : STATUS_OK;
              slot     <= CW'(1);
            end
            default: begin
              item     <= 32'sd0;
              status_r <= STATUS_OK;
              slot     <= CW'(1);
            end
          endcase
        end
      end
      ST_INS_CMP: begin
        if (rd0 < val) begin
          slot <= parent;
        end
      end
      ST_REM_LAST: begin
        val <= rd0;
      end
      ST_REM_CMP: begin
        if (pick_left) begin
          slot <= CW'(left);
        end else if (pick_right) begin
          slot <= CW'(right);
        end
      end
      ST_LIST_OUT: begin
        slot <= slot + CW'(1);
      end
      default: begin
        slot <= slot;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("Accepted item did not make the queue busy.");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == STATUS_FULL) |-> count == CW'(CAPACITY))
    else $error("Full status reported while the heap has room.");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == STATUS_EMPTY) |-> count == '0)
    else $error("Empty status reported while the heap holds entries.");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_REM_CMP && (pick_left || pick_right)) |-> has_left)
    else $error("Sift down chose a child that does not exist.");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the max-heap priority queue core, with directed and random items.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mhpq_pkg::*;

  localparam int HEAP_DEPTH = 16;
  localparam int RANDOM_ITEMS = 295;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;
  localparam logic signed [31:0] MAX_VAL = 32'sh7fff_ffff;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] value;
    bit                 typed;
    mhpq_rsp_t          rsp;
  } directed_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  mhpq_req_t request = '0;
  logic      busy;
  logic      result_valid;
  mhpq_rsp_t result;

  logic signed [31:0] model_heap [1:HEAP_DEPTH];
  int                 model_fill = 0;
  mhpq_rsp_t          pending_results [$];
  int                 error_count = 0;

  directed_row_t directed_rows [25] = '{
    '{OP_REMOVE, 0, 1'b1, '{0, 0, 0, STATUS_EMPTY, 1'b1}},
    '{OP_LIST, 0, 1'b1, '{0, 0, 0, STATUS_EMPTY, 1'b1}},
    '{OP_UNUSED, -1, 1'b1, '{0, 0, 0, STATUS_OK, 1'b1}},
    '{OP_INSERT, MIN_VAL, 1'b1, '{0, MIN_VAL, 1, STATUS_OK, 1'b1}},
    '{OP_INSERT, MAX_VAL, 1'b1, '{0, MAX_VAL, 2, STATUS_OK, 1'b1}},
    '{OP_INSERT, 0, 1'b1, '{0, MAX_VAL, 3, STATUS_OK, 1'b1}},
    '{OP_INSERT, -1, 1'b0, '0},
    '{OP_INSERT, 5, 1'b0, '0},
    '{OP_INSERT, 5, 1'b0, '0},
    '{OP_LIST, 0, 1'b0, '0},
    '{OP_REMOVE, 0, 1'b1, '{MAX_VAL, 5, 5, STATUS_OK, 1'b1}},
    '{OP_INSERT, 100, 1'b0, '0},
    '{OP_INSERT, -100, 1'b0, '0},
    '{OP_INSERT, MAX_VAL, 1'b0, '0},
    '{OP_INSERT, 3, 1'b0, '0},
    '{OP_INSERT, 3, 1'b0, '0},
    '{OP_INSERT, -50, 1'b0, '0},
    '{OP_INSERT, 64, 1'b0, '0},
    '{OP_INSERT, 1000, 1'b0, '0},
    '{OP_INSERT, MIN_VAL, 1'b0, '0},
    '{OP_INSERT, 17, 1'b0, '0},
    '{OP_INSERT, 9, 1'b0, '0},
    '{OP_INSERT, 42, 1'b1, '{0, MAX_VAL, 16, STATUS_FULL, 1'b1}},
    '{OP_LIST, 0, 1'b0, '0},
    '{OP_UNUSED, 0, 1'b0, '0}
  };

  max_heap_priority_queue_core #(
    .CAPACITY(HEAP_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .result_valid(result_valid),
    .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic mhpq_rsp_t heap_result(input logic signed [31:0] item,
                                            input logic [1:0] status, input bit is_last);
    mhpq_rsp_t rsp;
    rsp.item_value  = item;
    rsp.top_value   = (model_fill > 0) ? model_heap[1] : '0;
    rsp.entry_count = 5'(model_fill);
    rsp.status      = status;
    rsp.last        = is_last;
    return rsp;
  endfunction

  function automatic void predict_heap_op(input mhpq_req_t req, ref mhpq_rsp_t results [$]);
    int                 slot;
    int                 node;
    int                 left;
    int                 right;
    int                 pick;
    logic signed [31:0] removed;
    logic signed [31:0] held;
    case (req.operation)
      OP_INSERT: begin
        if (model_fill >= HEAP_DEPTH) begin
          results.push_back(heap_result('0, STATUS_FULL, 1'b1));
        end else begin
          model_fill++;
          slot = model_fill;
          while (slot > 1 && model_heap[slot / 2] < req.value) begin
            model_heap[slot] = model_heap[slot / 2];
            slot = slot / 2;
          end
          model_heap[slot] = req.value;
          results.push_back(heap_result('0, STATUS_OK, 1'b1));
        end
      end
      OP_REMOVE: begin
        if (model_fill == 0) begin
          results.push_back(heap_result('0, STATUS_EMPTY, 1'b1));
        end else begin
          removed = model_heap[1];
          model_heap[1] = model_heap[model_fill];
          model_fill--;
          node = 1;
          forever begin
            left = 2 * node;
            right = left + 1;
            pick = node;
            if (right <= model_fill) begin
              if (model_heap[left] >= model_heap[right] && model_heap[left] > model_heap[node])
                pick = left;
              else if (model_heap[right] > model_heap[left] &&
                       model_heap[right] > model_heap[node])
                pick = right;
            end else if (left <= model_fill) begin
              if (model_heap[left] > model_heap[node])
                pick = left;
            end
            if (pick == node)
              break;
            held = model_heap[node];
            model_heap[node] = model_heap[pick];
            model_heap[pick] = held;
            node = pick;
          end
          results.push_back(heap_result(removed, STATUS_OK, 1'b1));
        end
      end
      OP_LIST: begin
        if (model_fill == 0) begin
          results.push_back(heap_result('0, STATUS_EMPTY, 1'b1));
        end else begin
          for (int k = 1; k <= model_fill; k++)
            results.push_back(heap_result(model_heap[k], STATUS_OK, k == model_fill));
        end
      end
      default: begin
        results.push_back(heap_result('0, STATUS_OK, 1'b1));
      end
    endcase
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(99);
    if (quiet || r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic issue_item(input mhpq_req_t req, input int gap, input bit typed,
                            input mhpq_rsp_t typed_rsp);
    mhpq_rsp_t predicted [$];
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request <= req;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predict_heap_op(req, predicted);
    if (typed)
      pending_results.push_back(typed_rsp);
    else
      foreach (predicted[k]) pending_results.push_back(predicted[k]);
  endtask

  always @(posedge clk) begin
    mhpq_rsp_t want;
    if (!rst && result_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: %p", result));
      end else begin
        want = pending_results.pop_front();
        if (result.item_value !== want.item_value)
          report_mismatch($sformatf("item_value %0d, predicted %0d",
                                    result.item_value, want.item_value));
        if (result.top_value !== want.top_value)
          report_mismatch($sformatf("top_value %0d, predicted %0d",
                                    result.top_value, want.top_value));
        if (result.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, predicted %0d",
                                    result.entry_count, want.entry_count));
        if (result.status !== want.status)
          report_mismatch($sformatf("status %0d, predicted %0d", result.status, want.status));
        if (result.last !== want.last)
          report_mismatch($sformatf("last %0b, predicted %0b", result.last, want.last));
      end
    end
  end

  initial begin
    mhpq_req_t req;
    int        insert_pct;
    bit        quiet;
    int        r;
    insert_pct = 50;
    quiet = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      req.operation = directed_rows[i].op;
      req.value = directed_rows[i].value;
      issue_item(req, pick_gap(1'b0), directed_rows[i].typed, directed_rows[i].rsp);
    end

    // Phases lean toward filling or draining so that both full and empty are reached often.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 30 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 85;
          1: insert_pct = 15;
          default: insert_pct = 50;
        endcase
        quiet = ($urandom_range(3) == 0);
      end
      r = $urandom_range(99);
      if (r < 8)
        req.operation = OP_LIST;
      else if (r < 11)
        req.operation = OP_UNUSED;
      else if (r < 11 + (insert_pct * 89) / 100)
        req.operation = OP_INSERT;
      else
        req.operation = OP_REMOVE;
      case ($urandom_range(9))
        0: req.value = MIN_VAL;
        1: req.value = MAX_VAL;
        2, 3, 4, 5: req.value = int'($urandom_range(8)) - 4;
        default: req.value = $urandom();
      endcase
      issue_item(req, pick_gap(quiet), 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
